### design/grma_pkg.sv
// ----------------------------------------------------------------------------
// grma_pkg
// Shared constants and types of the gravity removed motion acceleration block.
// ----------------------------------------------------------------------------
package grma_pkg;

	localparam int QUAT_W = 32;
	localparam int DT_W   = 24;
	localparam int TAU_W  = 24;
	localparam int GRAV_W = 31;
	localparam int DEN_W  = 25;
	localparam int CFG_W  = 31;

	localparam logic [0:0] REG_TAU  = 1'b0;
	localparam logic [0:0] REG_GRAV = 1'b1;

	typedef struct packed {
		logic full;
		logic empty;
	} grma_qstat_t;

endpackage

### design/grma_front.sv
// ----------------------------------------------------------------------------
// grma_front
// Input stage: takes one item, works out the filter divisor and marks items
// whose divisor is zero, then hands the item to the queue.
// ----------------------------------------------------------------------------
module grma_front import grma_pkg::*; #(
	parameter int IN_BITS = 248,
	parameter int WORD_W  = 274
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [IN_BITS-1:0]  in_bits,
	input  logic [TAU_W-1:0]    tau,
	input  grma_qstat_t         qstat,
	output logic                push,
	output logic [WORD_W-1:0]   word
);

	logic              vld_q;
	logic [WORD_W-1:0] word_q;
	logic [DT_W-1:0]   dt;
	logic [DEN_W-1:0]  den;
	logic              hold;
	logic              take;

	assign dt       = in_bits[IN_BITS-1 -: DT_W];
	assign den      = {1'b0, tau} + {1'b0, dt};
	assign hold     = (den == '0);
	assign push     = vld_q && !qstat.full;
	assign s_tready = !vld_q || !qstat.full;
	assign take     = s_tvalid && s_tready;
	assign word     = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= take || (vld_q && !push);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			word_q <= {hold, den, in_bits};
		end
	end

endmodule

### design/grma_queue.sv
// ----------------------------------------------------------------------------
// grma_queue
// Short first-in first-out queue between the input stage and the datapath.
// ----------------------------------------------------------------------------
module grma_queue import grma_pkg::*; #(
	parameter int WIDTH = 274,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output grma_qstat_t      qstat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wp_q;
	logic [PW-1:0]    rp_q;
	logic [CW-1:0]    cnt_q;

	assign rdata       = mem_q[rp_q];
	assign qstat.full  = (cnt_q == CW'(DEPTH));
	assign qstat.empty = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wdata;
		end
	end

endmodule

### design/grma_back.sv
// ----------------------------------------------------------------------------
// grma_back
// Sequenced datapath: one shared multiplier builds the rotation matrix, the
// body-frame gravity, the filter numerators and the earth-frame vector; a
// restoring divider forms each filter quotient one bit per cycle.
// ----------------------------------------------------------------------------
module grma_back import grma_pkg::*; #(
	parameter int AW     = 32,
	parameter int WORD_W = 274
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [WORD_W-1:0] word,
	input  grma_qstat_t       qstat,
	output logic              pop,
	input  logic [TAU_W-1:0]  tau,
	input  logic [GRAV_W-1:0] grav,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [9*AW-1:0]   res
);

	localparam int ACC_W = AW + 52;
	localparam int DW    = AW + 28;
	localparam int CW    = $clog2(DW + 1);
	localparam int HW    = AW - 15;
	localparam int QB    = 3 * AW;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_QP    = 4'd1;
	localparam logic [3:0] ST_MAT   = 4'd2;
	localparam logic [3:0] ST_GRAV  = 4'd3;
	localparam logic [3:0] ST_NUM   = 4'd4;
	localparam logic [3:0] ST_DIV   = 4'd5;
	localparam logic [3:0] ST_FIN   = 4'd6;
	localparam logic [3:0] ST_EARTH = 4'd7;
	localparam logic [3:0] ST_OUT   = 4'd8;

	localparam logic signed [ACC_W-1:0] RND = ACC_W'(64'sd536870912);
	localparam logic signed [39:0]      ONE = 40'sd1073741824;

	logic [3:0]               state_q;
	logic [3:0]               step_q;
	logic [1:0]               axis_q;
	logic                     ph_q;
	logic signed [AW-1:0]     a_q  [3];
	logic signed [31:0]       qv_q [4];
	logic [DT_W-1:0]          dt_q;
	logic [DEN_W-1:0]         den_q;
	logic                     hold_q;
	logic signed [35:0]       pr_q [9];
	logic signed [31:0]       r_q  [9];
	logic signed [AW-1:0]     gb_q [3];
	logic signed [AW-1:0]     st_q [3];
	logic signed [AW-1:0]     ea_q [3];
	logic signed [65:0]       p_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic [25:0]              rem_q;
	logic [DW-1:0]            mag_q;
	logic                     neg_q;
	logic [CW-1:0]            cnt_q;
	logic [9*AW-1:0]          res_q;
	logic                     ovld_q;

	logic signed [32:0]       op_a;
	logic signed [32:0]       op_b;
	logic                     sh;
	logic [3:0]               ridx;
	logic [1:0]               sidx;
	logic signed [31:0]       r_sel;
	logic signed [AW:0]       d;
	logic signed [AW:0]       o;
	logic signed [AW:0]       d_sh;
	logic signed [AW:0]       o_sh;
	logic signed [ACC_W-1:0]  pe;
	logic signed [ACC_W-1:0]  acc_nx;
	logic signed [ACC_W-1:0]  rnd_p;
	logic signed [ACC_W-1:0]  rnd_a;
	logic signed [ACC_W-1:0]  xnum;
	logic signed [ACC_W-1:0]  xmag;
	logic signed [ACC_W-1:0]  uq;
	logic signed [ACC_W-1:0]  qs;
	logic [26:0]              rn;
	logic [25:0]              dd;
	logic                     ge;
	logic signed [31:0]       mat [9];
	logic signed [39:0]       pe40 [9];

	function automatic logic signed [AW-1:0] sat_aw(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = $signed({{(ACC_W - AW + 1){1'b0}}, {(AW - 1){1'b1}}});
		lo = ~hi;
		if (v > hi) begin
			return hi[AW-1:0];
		end else if (v < lo) begin
			return lo[AW-1:0];
		end
		return v[AW-1:0];
	endfunction

	function automatic logic signed [31:0] clamp_one(input logic signed [39:0] v);
		if (v > ONE) begin
			return 32'sd1073741824;
		end else if (v < -ONE) begin
			return -32'sd1073741824;
		end
		return v[31:0];
	endfunction

	assign pop      = (state_q == ST_IDLE) && !qstat.empty;
	assign m_tvalid = ovld_q;
	assign res      = res_q;

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			pe40[i] = 40'(pr_q[i]);
		end
		mat[0] = clamp_one(ONE - 40'sd2 * (pe40[1] + pe40[2]));
		mat[1] = clamp_one(40'sd2 * (pe40[3] - pe40[8]));
		mat[2] = clamp_one(40'sd2 * (pe40[4] + pe40[7]));
		mat[3] = clamp_one(40'sd2 * (pe40[3] + pe40[8]));
		mat[4] = clamp_one(ONE - 40'sd2 * (pe40[0] + pe40[2]));
		mat[5] = clamp_one(40'sd2 * (pe40[5] - pe40[6]));
		mat[6] = clamp_one(40'sd2 * (pe40[4] - pe40[7]));
		mat[7] = clamp_one(40'sd2 * (pe40[5] + pe40[6]));
		mat[8] = clamp_one(ONE - 40'sd2 * (pe40[0] + pe40[1]));
	end

	assign ridx  = (state_q == ST_EARTH) ? (4'(axis_q) * 4'd3 + {2'b0, step_q[2:1]})
	                                     : (4'd6 + step_q);
	assign sidx  = (state_q == ST_EARTH) ? step_q[2:1] : axis_q;
	assign r_sel = r_q[ridx];
	assign d     = (AW+1)'(a_q[axis_q]) - (AW+1)'(gb_q[axis_q]);
	assign o     = (AW+1)'(st_q[sidx]);
	assign d_sh  = d >>> 16;
	assign o_sh  = o >>> 16;

	always_comb begin
		op_a = '0;
		op_b = '0;
		sh   = 1'b0;
		case (state_q)
			ST_QP: begin
				case (step_q)
					4'd0: begin op_a = 33'(qv_q[1]); op_b = 33'(qv_q[1]); end
					4'd1: begin op_a = 33'(qv_q[2]); op_b = 33'(qv_q[2]); end
					4'd2: begin op_a = 33'(qv_q[3]); op_b = 33'(qv_q[3]); end
					4'd3: begin op_a = 33'(qv_q[1]); op_b = 33'(qv_q[2]); end
					4'd4: begin op_a = 33'(qv_q[1]); op_b = 33'(qv_q[3]); end
					4'd5: begin op_a = 33'(qv_q[2]); op_b = 33'(qv_q[3]); end
					4'd6: begin op_a = 33'(qv_q[0]); op_b = 33'(qv_q[1]); end
					4'd7: begin op_a = 33'(qv_q[0]); op_b = 33'(qv_q[2]); end
					default: begin op_a = 33'(qv_q[0]); op_b = 33'(qv_q[3]); end
				endcase
			end
			ST_GRAV: begin
				op_a = 33'(r_sel);
				op_b = $signed({2'b0, grav});
			end
			ST_NUM: begin
				case (step_q[1:0])
					2'd0: begin
						op_a = $signed({9'b0, dt_q});
						op_b = $signed({17'b0, d[15:0]});
					end
					2'd1: begin
						op_a = $signed({9'b0, dt_q});
						op_b = 33'($signed(d_sh[HW-1:0]));
						sh   = 1'b1;
					end
					2'd2: begin
						op_a = $signed({9'b0, tau});
						op_b = $signed({17'b0, o[15:0]});
					end
					default: begin
						op_a = $signed({9'b0, tau});
						op_b = 33'($signed(o_sh[HW-1:0]));
						sh   = 1'b1;
					end
				endcase
			end
			ST_EARTH: begin
				op_a = 33'(r_sel);
				op_b = step_q[0] ? 33'($signed(o_sh[HW-1:0])) : $signed({17'b0, o[15:0]});
				sh   = step_q[0];
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign pe     = ACC_W'(p_q);
	assign acc_nx = acc_q + (sh ? (pe <<< 16) : pe);
	assign rnd_p  = (pe + RND) >>> 30;
	assign rnd_a  = (acc_nx + RND) >>> 30;
	assign xnum   = (acc_nx <<< 1) + $signed({{(ACC_W - DEN_W){1'b0}}, den_q});
	assign xmag   = xnum[ACC_W-1] ? -xnum : xnum;
	assign dd     = {den_q, 1'b0};
	assign rn     = {rem_q, mag_q[DW-1]};
	assign ge     = (rn >= {1'b0, dd});
	assign uq     = $signed({{(ACC_W - DW){1'b0}}, mag_q});
	assign qs     = neg_q ? ((rem_q != '0) ? (-uq - ACC_W'(1)) : -uq) : uq;

	always_ff @(posedge clk) begin
		p_q <= op_a * op_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			axis_q  <= '0;
			ph_q    <= 1'b0;
			cnt_q   <= '0;
			ovld_q  <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				st_q[i] <= '0;
			end
		end else begin
			if (state_q == ST_OUT && (!ovld_q || m_tready)) begin
				ovld_q <= 1'b1;
			end else if (m_tready) begin
				ovld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_QP;
						step_q  <= '0;
						ph_q    <= 1'b0;
					end
				end
				ST_QP: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						if (step_q == 4'd8) begin
							state_q <= ST_MAT;
							step_q  <= '0;
						end else begin
							step_q <= step_q + 1'b1;
						end
					end
				end
				ST_MAT: begin
					state_q <= ST_GRAV;
					step_q  <= '0;
					ph_q    <= 1'b0;
				end
				ST_GRAV: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						if (step_q == 4'd2) begin
							state_q <= hold_q ? ST_EARTH : ST_NUM;
							step_q  <= '0;
							axis_q  <= '0;
						end else begin
							step_q <= step_q + 1'b1;
						end
					end
				end
				ST_NUM: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						if (step_q == 4'd3) begin
							state_q <= ST_DIV;
							step_q  <= '0;
							cnt_q   <= '0;
						end else begin
							step_q <= step_q + 1'b1;
						end
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(DW - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					st_q[axis_q] <= sat_aw(qs);
					ph_q         <= 1'b0;
					step_q       <= '0;
					if (axis_q == 2'd2) begin
						state_q <= ST_EARTH;
						axis_q  <= '0;
					end else begin
						state_q <= ST_NUM;
						axis_q  <= axis_q + 1'b1;
					end
				end
				ST_EARTH: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						if (step_q == 4'd5) begin
							step_q <= '0;
							if (axis_q == 2'd2) begin
								state_q <= ST_OUT;
								axis_q  <= '0;
							end else begin
								axis_q <= axis_q + 1'b1;
							end
						end else begin
							step_q <= step_q + 1'b1;
						end
					end
				end
				ST_OUT: begin
					if (!ovld_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			for (int i = 0; i < 3; i++) begin
				a_q[i] <= word[i*AW +: AW];
			end
			for (int i = 0; i < 4; i++) begin
				qv_q[i] <= word[QB + i*QUAT_W +: QUAT_W];
			end
			dt_q   <= word[QB + 4*QUAT_W +: DT_W];
			den_q  <= word[QB + 4*QUAT_W + DT_W +: DEN_W];
			hold_q <= word[QB + 4*QUAT_W + DT_W + DEN_W];
		end
		if (state_q == ST_QP && ph_q) begin
			pr_q[step_q] <= rnd_p[35:0];
		end
		if (state_q == ST_MAT) begin
			for (int i = 0; i < 9; i++) begin
				r_q[i] <= mat[i];
			end
		end
		if (state_q == ST_GRAV && ph_q) begin
			gb_q[step_q[1:0]] <= sat_aw(rnd_p);
		end
		if (state_q == ST_GRAV || state_q == ST_FIN) begin
			acc_q <= '0;
		end else if ((state_q == ST_NUM || state_q == ST_EARTH) && ph_q) begin
			acc_q <= ((state_q == ST_EARTH && step_q == 4'd5)) ? '0 : acc_nx;
		end
		if (state_q == ST_NUM && ph_q && step_q == 4'd3) begin
			neg_q <= xnum[ACC_W-1];
			mag_q <= xmag[DW-1:0];
			rem_q <= '0;
		end
		if (state_q == ST_DIV) begin
			rem_q <= ge ? 26'(rn - {1'b0, dd}) : rn[25:0];
			mag_q <= {mag_q[DW-2:0], ge};
		end
		if (state_q == ST_EARTH && ph_q && step_q == 4'd5) begin
			ea_q[axis_q] <= sat_aw(rnd_a);
		end
		if (state_q == ST_OUT && (!ovld_q || m_tready)) begin
			res_q <= {gb_q[2], gb_q[1], gb_q[0], st_q[2], st_q[1], st_q[0],
			          ea_q[2], ea_q[1], ea_q[0]};
		end
	end

endmodule

### design/gravity_removed_motion_accel.sv
// ----------------------------------------------------------------------------
// gravity_removed_motion_accel
// Removes gravity from an accelerometer sample, low-pass filters the motion
// part in the body frame and rotates it into the earth frame.
// ----------------------------------------------------------------------------
// Input items arrive on the s_ channel: the body sample, the attitude
// quaternion and the elapsed time. Each accepted item yields exactly one
// result item on the m_ channel with the earth and body motion vectors and
// the gravity vector seen in the body frame.
// The user must write the filter time constant and the gravity magnitude
// through cfg_we, cfg_index and cfg_data only while no item is in flight;
// the block does not enforce this. Each item is worked through from the
// queue to the output register, with the filter steps skipped and the state
// held when the filter divisor is zero. The single shared multiplier forms
// every product in turn, and the restoring divider gives one quotient bit
// per cycle for each axis.
// An input stage and a two-entry queue take up to three further items while
// the datapath is busy; a finished result waits in the output register
// while the datapath starts on the next item.
// Reset clears the filter state to zero, loads the register defaults and
// empties the queue. A stalled receiver holds the result steady.
// ----------------------------------------------------------------------------
module gravity_removed_motion_accel import grma_pkg::*; #(
	parameter int ACCEL_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	// accel_x, accel_y, accel_z, quat_w, quat_x, quat_y, quat_z, elapsed_time
	input  logic [((3*ACCEL_WIDTH+152+7)/8)*8-1:0] s_tdata,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// motion_earth_x/y/z, motion_body_x/y/z, gravity_body_x/y/z
	output logic [((9*ACCEL_WIDTH+7)/8)*8-1:0]     m_tdata,
	input  logic                     cfg_we,
	input  logic [0:0]               cfg_index,
	input  logic [CFG_W-1:0]         cfg_data
);

	localparam int IN_BITS = 3*ACCEL_WIDTH + 4*QUAT_W + DT_W;
	localparam int OUT_W   = ((9*ACCEL_WIDTH + 7) / 8) * 8;
	localparam int WORD_W  = IN_BITS + DEN_W + 1;

	logic [TAU_W-1:0]         tau_q;
	logic [GRAV_W-1:0]        grav_q;
	logic                     push;
	logic                     pop;
	logic [WORD_W-1:0]        fword;
	logic [WORD_W-1:0]        bword;
	grma_qstat_t              qstat;
	logic [9*ACCEL_WIDTH-1:0] res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tau_q  <= 24'd142606;
			grav_q <= 31'd642908;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TAU:  tau_q  <= cfg_data[TAU_W-1:0];
				REG_GRAV: grav_q <= cfg_data[GRAV_W-1:0];
				default:  ;
			endcase
		end
	end

	grma_front #(.IN_BITS(IN_BITS), .WORD_W(WORD_W)) u_front (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.in_bits(s_tdata[IN_BITS-1:0]), .tau(tau_q), .qstat(qstat),
		.push(push), .word(fword)
	);

	grma_queue #(.WIDTH(WORD_W), .DEPTH(2)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata(fword), .pop(pop),
		.rdata(bword), .qstat(qstat)
	);

	grma_back #(.AW(ACCEL_WIDTH), .WORD_W(WORD_W)) u_back (
		.clk(clk), .arst_n(arst_n), .word(bword), .qstat(qstat), .pop(pop),
		.tau(tau_q), .grav(grav_q), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.res(res)
	);

	assign m_tdata = OUT_W'(res);

endmodule

### design/grma_checker.sv
// ----------------------------------------------------------------------------
// grma_props
// Port-level checks on the stream channels of the block.
// ----------------------------------------------------------------------------
module grma_props #(
	parameter int OUT_W = 288
) (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	logic [2:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + 3'(s_tvalid && s_tready) - 3'(m_tvalid && m_tready);
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_reset: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("result valid during reset");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 3'd5 |-> !s_tready)
		else $error("item taken beyond capacity");

	a_cap: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 3'd5)
		else $error("too many items in flight");

	a_src: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> cnt_q != 3'd0)
		else $error("result without an item in flight");

endmodule

bind gravity_removed_motion_accel grma_props #(.OUT_W(OUT_W)) u_grma_props (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
